>>> sv/fodm_pkg.sv
// Shared types, widths and constants for the field-oriented omni drive mixer.
package fodm_pkg;

    localparam int DIRW      = 17;   // travel direction, hundredths of a degree
    localparam int YAWW      = 16;   // heading, hundredths of a degree
    localparam int SW        = 13;   // speed, Q12
    localparam int RW        = 15;   // turn rate, signed Q12
    localparam int BW        = 18;   // direction minus heading
    localparam int AW        = 15;   // folded angle, [-9000, 9000]
    localparam int XW        = 34;   // CORDIC x and y, Q30 plus headroom
    localparam int ZW        = 32;   // CORDIC residual angle
    localparam int CW        = 16;   // sine and cosine, Q14
    localparam int VW        = 30;   // speed times sine or cosine, Q26
    localparam int PW        = 47;   // diagonal product
    localparam int WW        = 18;   // wheel speed, Q12
    localparam int MAGW      = 17;   // wheel speed magnitude
    localparam int GW        = 9;    // motor gain, Q8
    localparam int DUTYW     = 8;
    localparam int LANES     = 4;

    localparam int ATAN_LEN    = 24;
    localparam int CORDIC_K    = 652032875;
    localparam int DIAG        = 11585;
    localparam int FULL_TURN   = 36000;
    localparam int HALF_TURN   = 18000;
    localparam int QUARTER     = 9000;
    localparam int WRAP_OFFSET = 108000;
    localparam int SPEED_FULL  = 4096;
    localparam int DUTY_LIMIT  = 255;
    localparam int GAIN_ONE    = 256;

    typedef enum logic [2:0] {
        REG_YAW_REVERSE = 3'd0,
        REG_GAIN_MOTOR1 = 3'd1,
        REG_GAIN_MOTOR2 = 3'd2,
        REG_GAIN_MOTOR3 = 3'd3,
        REG_GAIN_MOTOR4 = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [SW-1:0]        spd;
        logic signed [RW-1:0] rot;
        logic                 neg;
    } cordic_side_t;

    // arctan(2^-i) in units of 1/65536 hundredth degree
    function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] idx);
        logic signed [ZW-1:0] a;
        case (idx)
            5'd0:    a = 32'sd294912000;
            5'd1:    a = 32'sd174096719;
            5'd2:    a = 32'sd91987925;
            5'd3:    a = 32'sd46694507;
            5'd4:    a = 32'sd23437865;
            5'd5:    a = 32'sd11730358;
            5'd6:    a = 32'sd5866610;
            5'd7:    a = 32'sd2933484;
            5'd8:    a = 32'sd1466765;
            5'd9:    a = 32'sd733385;
            5'd10:   a = 32'sd366693;
            5'd11:   a = 32'sd183346;
            5'd12:   a = 32'sd91673;
            5'd13:   a = 32'sd45837;
            5'd14:   a = 32'sd22918;
            5'd15:   a = 32'sd11459;
            5'd16:   a = 32'sd5730;
            5'd17:   a = 32'sd2865;
            5'd18:   a = 32'sd1432;
            5'd19:   a = 32'sd716;
            5'd20:   a = 32'sd358;
            5'd21:   a = 32'sd179;
            5'd22:   a = 32'sd90;
            5'd23:   a = 32'sd45;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> sv/field_oriented_omni_drive_mixer_core.sv
// Top level of the field-oriented four-wheel omni drive mixer.
//
// Usage: each input word carries a field-frame travel direction, a speed,
// a turn rate and the current heading; each output word carries forward and
// reverse duties for the four motors. Both channels hand over a word when
// valid is high and stall is low. Configuration (yaw reverse and the four
// Q8 motor gains) is written through cfg_write / cfg_index / cfg_data while
// no word is in flight; indexes past the list are ignored.
// Pipeline order: angle wrap, CORDIC_STAGES iterations (capped at 24),
// rounding, the mixing stages, one divider stage per quotient bit, then
// gain and clamp. Throughput: one word per cycle while out_stall is low,
// set by the per-stage CORDIC iterations and the bit-per-stage divider,
// which are fully pipelined.
// Reset clears all valid bits, yaw reverse to 0 and every gain to 256.
// A stalled receiver holds the output word; empty stages behind it still
// fill, so input is accepted until the whole pipeline is full.
module field_oriented_omni_drive_mixer_core #(
    parameter int CORDIC_STAGES  = 16,
    parameter int PWM_FULL_SCALE = 255
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [2:0]                          cfg_index,
    input  logic [fodm_pkg::GW-1:0]             cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [fodm_pkg::DIRW-1:0]    travel_direction,
    input  logic [fodm_pkg::SW-1:0]             travel_speed,
    input  logic signed [fodm_pkg::RW-1:0]      turn_rate,
    input  logic signed [fodm_pkg::YAWW-1:0]    heading_now,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fodm_pkg::DUTYW-1:0]          m1_fwd_duty,
    output logic [fodm_pkg::DUTYW-1:0]          m1_rev_duty,
    output logic [fodm_pkg::DUTYW-1:0]          m2_fwd_duty,
    output logic [fodm_pkg::DUTYW-1:0]          m2_rev_duty,
    output logic [fodm_pkg::DUTYW-1:0]          m3_fwd_duty,
    output logic [fodm_pkg::DUTYW-1:0]          m3_rev_duty,
    output logic [fodm_pkg::DUTYW-1:0]          m4_fwd_duty,
    output logic [fodm_pkg::DUTYW-1:0]          m4_rev_duty
);
    import fodm_pkg::*;

    localparam int QW = $clog2(PWM_FULL_SCALE + 1);  // quotient never exceeds full scale
    localparam int NW = MAGW + QW;                    // |w| * full scale
    localparam int MW = QW + GW;                      // quotient * gain

    // ---------------- configuration registers ----------------
    logic          yaw_rev_reg;
    logic [GW-1:0] gain_reg [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_rev_reg <= 1'b0;
            for (int l = 0; l < LANES; l++)
            begin
                gain_reg[l] <= GW'(GAIN_ONE);
            end
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_YAW_REVERSE: yaw_rev_reg <= cfg_data[0];
                REG_GAIN_MOTOR1: gain_reg[0] <= cfg_data;
                REG_GAIN_MOTOR2: gain_reg[1] <= cfg_data;
                REG_GAIN_MOTOR3: gain_reg[2] <= cfg_data;
                REG_GAIN_MOTOR4: gain_reg[3] <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------- stage 1: body angle, wrap and fold ----------------
    logic signed [BW-1:0] yaw_ext, body;
    logic [BW-1:0]        wrap_u;
    logic [BW-1:0]        wrap_m;
    logic signed [BW-1:0] half_r;
    logic signed [AW-1:0] angle_next;
    logic                 neg_next;
    logic [SW-1:0]        spd_next;

    always_comb
    begin
        yaw_ext = BW'(heading_now);
        if (yaw_rev_reg)
        begin
            yaw_ext = -yaw_ext;
        end
        body   = BW'(travel_direction) - yaw_ext;
        // shift to a positive range, then take off whole turns
        wrap_u = BW'(body) + BW'(WRAP_OFFSET);
        if (wrap_u >= BW'(5 * FULL_TURN))
            wrap_m = wrap_u - BW'(5 * FULL_TURN);
        else if (wrap_u >= BW'(4 * FULL_TURN))
            wrap_m = wrap_u - BW'(4 * FULL_TURN);
        else if (wrap_u >= BW'(3 * FULL_TURN))
            wrap_m = wrap_u - BW'(3 * FULL_TURN);
        else if (wrap_u >= BW'(2 * FULL_TURN))
            wrap_m = wrap_u - BW'(2 * FULL_TURN);
        else if (wrap_u >= BW'(FULL_TURN))
            wrap_m = wrap_u - BW'(FULL_TURN);
        else
            wrap_m = wrap_u;
        half_r = (wrap_m >= BW'(HALF_TURN)) ? $signed(wrap_m - BW'(FULL_TURN))
                                            : $signed(wrap_m);
        // fold into the CORDIC range, negate sine and cosine afterwards
        neg_next = 1'b0;
        if (half_r > BW'(QUARTER))
        begin
            angle_next = AW'(half_r - BW'(HALF_TURN));
            neg_next   = 1'b1;
        end
        else if (half_r < -BW'(QUARTER))
        begin
            angle_next = AW'(half_r + BW'(HALF_TURN));
            neg_next   = 1'b1;
        end
        else
        begin
            angle_next = AW'(half_r);
        end
        spd_next = (travel_speed > SW'(SPEED_FULL)) ? SW'(SPEED_FULL) : travel_speed;
    end

    logic                 s1_v_reg;
    logic signed [AW-1:0] s1_angle_reg;
    cordic_side_t         s1_side_reg;
    logic                 cor_in_stall;
    logic                 s1_rdy;

    assign s1_rdy   = !s1_v_reg || !cor_in_stall;
    assign in_stall = !s1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (s1_rdy)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy)
        begin
            s1_angle_reg    <= angle_next;
            s1_side_reg.spd <= spd_next;
            s1_side_reg.rot <= turn_rate;
            s1_side_reg.neg <= neg_next;
        end
    end

    // ---------------- CORDIC ----------------
    logic                 cor_out_valid;
    logic signed [CW-1:0] cor_cos, cor_sin;
    cordic_side_t         cor_side;
    logic                 cor_out_stall;

    fodm_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_v_reg),
        .in_stall  (cor_in_stall),
        .in_angle  (s1_angle_reg),
        .in_side   (s1_side_reg),
        .out_valid (cor_out_valid),
        .out_stall (cor_out_stall),
        .out_cos   (cor_cos),
        .out_sin   (cor_sin),
        .out_side  (cor_side)
    );

    // ---------------- mixing stages (five) ----------------
    localparam int MS = 5;
    logic [MS-1:0] mv_reg;
    logic [MS:0]   mrdy;
    logic [MS:0]   mv_chain;
    logic          div_in_stall;

    always_comb
    begin
        mrdy[MS]    = !div_in_stall;
        mv_chain[0] = cor_out_valid;
        for (int k = MS - 1; k >= 0; k--)
        begin
            mrdy[k]       = !mv_reg[k] || mrdy[k+1];
            mv_chain[k+1] = mv_reg[k];
        end
    end
    assign cor_out_stall = !mrdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < MS; k++)
            begin
                if (mrdy[k])
                    mv_reg[k] <= mv_chain[k];
            end
        end
    end

    // stage B: velocity components, Q26
    logic signed [VW-1:0] vx_reg, vy_reg;
    logic signed [RW-1:0] b_rot_reg;

    always_ff @(posedge clk)
    begin
        if (mrdy[0])
        begin
            vx_reg    <= $signed({1'b0, cor_side.spd}) * cor_cos;
            vy_reg    <= $signed({1'b0, cor_side.spd}) * cor_sin;
            b_rot_reg <= cor_side.rot;
        end
    end

    // stage C: diagonal products
    localparam logic signed [15:0] DIAG_C = 16'(DIAG);
    logic signed [VW:0]   vsum, vdif;
    logic signed [PW-1:0] psum_reg, pdif_reg;
    logic signed [RW-1:0] c_rot_reg;

    assign vsum = (VW+1)'(vx_reg) + (VW+1)'(vy_reg);
    assign vdif = (VW+1)'(vy_reg) - (VW+1)'(vx_reg);

    always_ff @(posedge clk)
    begin
        if (mrdy[1])
        begin
            psum_reg  <= vsum * DIAG_C;
            pdif_reg  <= vdif * DIAG_C;
            c_rot_reg <= b_rot_reg;
        end
    end

    // stage D: round to Q12 and add the turn term
    logic signed [PW-1:0] psum_rnd, pdif_rnd;
    logic signed [WW-1:0] sum_q12, dif_q12, rot_ext;
    logic signed [WW-1:0] w_reg [LANES];

    always_comb
    begin
        psum_rnd = psum_reg + PW'(1 << 27);
        pdif_rnd = pdif_reg + PW'(1 << 27);
        sum_q12  = WW'(psum_rnd[PW-1:28]);
        dif_q12  = WW'(pdif_rnd[PW-1:28]);
        rot_ext  = WW'(c_rot_reg);
    end

    // lanes in motor order: +45, -45, +135, -135 degree wheels
    always_ff @(posedge clk)
    begin
        if (mrdy[2])
        begin
            w_reg[0] <= dif_q12 + rot_ext;
            w_reg[1] <= sum_q12 + rot_ext;
            w_reg[2] <= rot_ext - sum_q12;
            w_reg[3] <= rot_ext - dif_q12;
        end
    end

    // stage E: magnitudes and normalizing denominator
    logic [MAGW-1:0]  mag [LANES];
    logic [MAGW-1:0]  max01, max23, den_next;
    logic [MAGW-1:0]  mag_reg [LANES];
    logic [MAGW-1:0]  den_reg;
    logic [LANES-1:0] e_neg_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            mag[l] = w_reg[l][WW-1] ? MAGW'(-w_reg[l]) : MAGW'(w_reg[l]);
        end
        max01    = (mag[0] > mag[1]) ? mag[0] : mag[1];
        max23    = (mag[2] > mag[3]) ? mag[2] : mag[3];
        den_next = (max01 > max23) ? max01 : max23;
        if (den_next < MAGW'(SPEED_FULL))
            den_next = MAGW'(SPEED_FULL);
    end

    always_ff @(posedge clk)
    begin
        if (mrdy[3])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                mag_reg[l]   <= mag[l];
                e_neg_reg[l] <= w_reg[l][WW-1];
            end
            den_reg <= den_next;
        end
    end

    // stage F: scale numerators to full PWM
    logic [NW-1:0]    num_reg [LANES];
    logic [MAGW-1:0]  f_den_reg;
    logic [LANES-1:0] f_neg_reg;

    always_ff @(posedge clk)
    begin
        if (mrdy[4])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                num_reg[l] <= NW'(mag_reg[l]) * NW'(PWM_FULL_SCALE);
            end
            f_den_reg <= den_reg;
            f_neg_reg <= e_neg_reg;
        end
    end

    // ---------------- divider ----------------
    logic             div_out_valid;
    logic             div_out_stall;
    logic [QW-1:0]    quo [LANES];
    logic [LANES-1:0] quo_neg;

    fodm_div #(
        .QW (QW),
        .NW (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mv_reg[MS-1]),
        .in_stall  (div_in_stall),
        .in_num    (num_reg),
        .in_den    (f_den_reg),
        .in_neg    (f_neg_reg),
        .out_valid (div_out_valid),
        .out_stall (div_out_stall),
        .out_quo   (quo),
        .out_neg   (quo_neg)
    );

    // ---------------- output stage: gain, clamp, split ----------------
    logic             out_v_reg;
    logic             o_rdy;
    logic [MW-1:0]    prod [LANES];
    logic [MW-1:0]    scaled [LANES];
    logic [DUTYW-1:0] lim [LANES];
    logic [DUTYW-1:0] fwd_reg [LANES];
    logic [DUTYW-1:0] rev_reg [LANES];

    assign o_rdy         = !out_v_reg || !out_stall;
    assign div_out_stall = !o_rdy;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            prod[l]   = MW'(quo[l]) * MW'(gain_reg[l]);
            scaled[l] = prod[l] >> 8;
            lim[l]    = (scaled[l] > MW'(DUTY_LIMIT)) ? DUTYW'(DUTY_LIMIT)
                                                      : DUTYW'(scaled[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (o_rdy)
            out_v_reg <= div_out_valid;
    end

    always_ff @(posedge clk)
    begin
        if (o_rdy)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                fwd_reg[l] <= quo_neg[l] ? '0 : lim[l];
                rev_reg[l] <= quo_neg[l] ? lim[l] : '0;
            end
        end
    end

    assign out_valid   = out_v_reg;
    assign m1_fwd_duty = fwd_reg[0];
    assign m1_rev_duty = rev_reg[0];
    assign m2_fwd_duty = fwd_reg[1];
    assign m2_rev_duty = rev_reg[1];
    assign m3_fwd_duty = fwd_reg[2];
    assign m3_rev_duty = rev_reg[2];
    assign m4_fwd_duty = fwd_reg[3];
    assign m4_rev_duty = rev_reg[3];

endmodule

>>> sv/fodm_cordic.sv
// Pipelined rotation-mode CORDIC: one iteration per stage, Q14 rounded outputs.
module fodm_cordic #(
    parameter int STAGES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [fodm_pkg::AW-1:0] in_angle,
    input  fodm_pkg::cordic_side_t        in_side,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [fodm_pkg::CW-1:0] out_cos,
    output logic signed [fodm_pkg::CW-1:0] out_sin,
    output fodm_pkg::cordic_side_t        out_side
);
    import fodm_pkg::*;

    localparam int NS = (STAGES < ATAN_LEN) ? STAGES : ATAN_LEN;
    localparam int D  = NS + 1;

    logic signed [XW-1:0] x_reg [NS];
    logic signed [XW-1:0] y_reg [NS];
    logic signed [ZW-1:0] z_reg [NS];
    cordic_side_t         side_reg [NS];

    logic signed [CW-1:0] cos_reg;
    logic signed [CW-1:0] sin_reg;
    cordic_side_t         oside_reg;

    logic [D-1:0] v_reg;
    logic [D:0]   rdy;
    logic [D:0]   v_chain;

    always_comb
    begin
        rdy[D]     = !out_stall;
        v_chain[0] = in_valid;
        for (int k = D - 1; k >= 0; k--)
        begin
            rdy[k]       = !v_reg[k] || rdy[k+1];
            v_chain[k+1] = v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < D; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_chain[k];
                end
            end
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_iter
        logic signed [XW-1:0] xi, yi, dx, dy;
        logic signed [ZW-1:0] zi;
        cordic_side_t         si;

        if (k == 0)
        begin : g_first
            assign xi = XW'(CORDIC_K);
            assign yi = '0;
            assign zi = ZW'(in_angle) <<< 16;
            assign si = in_side;
        end
        else
        begin : g_next
            assign xi = x_reg[k-1];
            assign yi = y_reg[k-1];
            assign zi = z_reg[k-1];
            assign si = side_reg[k-1];
        end

        assign dx = yi >>> k;
        assign dy = xi >>> k;

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                if (!zi[ZW-1])
                begin
                    x_reg[k] <= xi - dx;
                    y_reg[k] <= yi + dy;
                    z_reg[k] <= zi - atan_step(5'(k));
                end
                else
                begin
                    x_reg[k] <= xi + dx;
                    y_reg[k] <= yi - dy;
                    z_reg[k] <= zi + atan_step(5'(k));
                end
                side_reg[k] <= si;
            end
        end
    end

    // round half up to Q14, undo the fold
    logic signed [XW-1:0] x_rnd, y_rnd;
    logic signed [CW-1:0] x_q14, y_q14;

    always_comb
    begin
        x_rnd = x_reg[NS-1] + XW'(32768);
        y_rnd = y_reg[NS-1] + XW'(32768);
        x_q14 = CW'(x_rnd[XW-1:16]);
        y_q14 = CW'(y_rnd[XW-1:16]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NS])
        begin
            cos_reg   <= side_reg[NS-1].neg ? -x_q14 : x_q14;
            sin_reg   <= side_reg[NS-1].neg ? -y_q14 : y_q14;
            oside_reg <= side_reg[NS-1];
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = v_reg[D-1];
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;
    assign out_side  = oside_reg;

endmodule

>>> sv/fodm_div.sv
// Four-lane pipelined restoring divider, one quotient bit per stage.
module fodm_div #(
    parameter int QW = 8,
    parameter int NW = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [NW-1:0]                 in_num [fodm_pkg::LANES],
    input  logic [fodm_pkg::MAGW-1:0]     in_den,
    input  logic [fodm_pkg::LANES-1:0]    in_neg,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [QW-1:0]                 out_quo [fodm_pkg::LANES],
    output logic [fodm_pkg::LANES-1:0]    out_neg
);
    import fodm_pkg::*;

    logic [NW-1:0]    rem_reg [QW][LANES];
    logic [QW-1:0]    quo_reg [QW][LANES];
    logic [MAGW-1:0]  den_reg [QW];
    logic [LANES-1:0] neg_reg [QW];

    logic [QW-1:0] v_reg;
    logic [QW:0]   rdy;
    logic [QW:0]   v_chain;

    always_comb
    begin
        rdy[QW]    = !out_stall;
        v_chain[0] = in_valid;
        for (int k = QW - 1; k >= 0; k--)
        begin
            rdy[k]       = !v_reg[k] || rdy[k+1];
            v_chain[k+1] = v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < QW; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_chain[k];
                end
            end
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_bit
        localparam int SH = QW - 1 - k;
        logic [NW-1:0]    ri [LANES];
        logic [QW-1:0]    qi [LANES];
        logic [MAGW-1:0]  di;
        logic [LANES-1:0] ni;
        logic [NW-1:0]    dsh;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    ri[l] = in_num[l];
                    qi[l] = '0;
                end
            end
            assign di = in_den;
            assign ni = in_neg;
        end
        else
        begin : g_next
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    ri[l] = rem_reg[k-1][l];
                    qi[l] = quo_reg[k-1][l];
                end
            end
            assign di = den_reg[k-1];
            assign ni = neg_reg[k-1];
        end

        assign dsh = NW'(di) << SH;

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    if (ri[l] >= dsh)
                    begin
                        rem_reg[k][l] <= ri[l] - dsh;
                        quo_reg[k][l] <= qi[l] | (QW'(1) << SH);
                    end
                    else
                    begin
                        rem_reg[k][l] <= ri[l];
                        quo_reg[k][l] <= qi[l];
                    end
                end
                den_reg[k] <= di;
                neg_reg[k] <= ni;
            end
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = v_reg[QW-1];
    assign out_neg   = neg_reg[QW-1];
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            out_quo[l] = quo_reg[QW-1][l];
        end
    end

endmodule
